>>> design/clock_offset_window_average_assert.svh
// Assertion macros for the clock offset window average block.
`ifndef CLOCK_OFFSET_WINDOW_AVERAGE_ASSERT_SVH
`define CLOCK_OFFSET_WINDOW_AVERAGE_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset.
`define COA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define COA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define COA_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define COA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

>>> design/coa_pkg.sv
// Shared constants and types for the clock offset window average block.
package coa_pkg;

  localparam int WINDOW_DEF  = 100;
  localparam int TAG_W       = 32;
  localparam int TIME_W      = 62;
  localparam int SAMPLE_W    = 48;
  localparam int HELD_W      = 7;
  localparam int DIFF_W      = 64;
  localparam int QUEUE_DEPTH = 2;

  // Request kinds carried on func
  typedef enum logic {
    EV_REQUEST  = 1'b0,
    EV_RECEIVED = 1'b1
  } event_kind_t;

  // Message kinds carried on is_reply
  typedef enum logic {
    MSG_QUERY = 1'b0,
    MSG_REPLY = 1'b1
  } msg_kind_t;

  // Classified request passed from front to back
  typedef struct packed {
    logic                       hit;
    logic signed [SAMPLE_W-1:0] sample;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_START,
    BK_WAIT
  } back_state_t;

endpackage

>>> design/coa_front.sv
// Front end: tag matching, offset sample forming and saturation.
module coa_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        func,
  input  logic [coa_pkg::TAG_W-1:0]   tag,
  input  logic                        is_reply,
  input  logic [coa_pkg::TIME_W-1:0]  client_request_time,
  input  logic [coa_pkg::TIME_W-1:0]  server_time,
  input  logic [coa_pkg::TIME_W-1:0]  receive_time,
  output logic                        q_push,
  output coa_pkg::cmd_t               q_data,
  input  logic                        q_full
);

  localparam int DW = coa_pkg::DIFF_W;
  localparam int SW = coa_pkg::SAMPLE_W;

  logic [coa_pkg::TAG_W-1:0] pending_tag;
  logic                      pending_valid;
  logic                      hold_valid;
  logic                      hold_hit;
  logic [DW-1:0]             hold_diff;

  logic          accept;
  logic          match;
  logic [DW-1:0] diff;
  logic [DW-1:0] rounded;
  logic [DW-1:0] half;
  logic          fits;

  assign full   = hold_valid && q_full;
  assign accept = push && !full;
  assign q_push = hold_valid && !q_full;

  // Classify: a reply counts only against the pending tag
  assign match = (func == coa_pkg::EV_RECEIVED) && (is_reply == coa_pkg::MSG_REPLY)
              && pending_valid && (tag == pending_tag);

  // Round-trip offset times two: 2*server - request - receive
  assign diff = {{(DW-coa_pkg::TIME_W){1'b0}}, server_time}
              + {{(DW-coa_pkg::TIME_W){1'b0}}, server_time}
              - {{(DW-coa_pkg::TIME_W){1'b0}}, client_request_time}
              - {{(DW-coa_pkg::TIME_W){1'b0}}, receive_time};

  // Halve toward zero, then saturate to the sample width
  assign rounded = hold_diff + {{(DW-1){1'b0}}, hold_diff[DW-1]};
  assign half    = {rounded[DW-1], rounded[DW-1:1]};
  assign fits    = (&half[DW-1:SW-1]) || !(|half[DW-1:SW-1]);

  always_comb begin
    q_data.hit = hold_hit;
    if (fits) begin
      q_data.sample = half[SW-1:0];
    end else if (half[DW-1]) begin
      q_data.sample = {1'b1, {(SW-1){1'b0}}};
    end else begin
      q_data.sample = {1'b0, {(SW-1){1'b1}}};
    end
  end

  // Track the pending request and hold the staged item
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_tag   <= '0;
      pending_valid <= 1'b0;
      hold_valid    <= 1'b0;
    end else begin
      if (accept) begin
        if (func == coa_pkg::EV_REQUEST) begin
          pending_tag   <= tag;
          pending_valid <= 1'b1;
        end else if (match) begin
          pending_valid <= 1'b0;
        end
      end
      if (accept) begin
        hold_valid <= 1'b1;
      end else if (q_push) begin
        hold_valid <= 1'b0;
      end
    end
  end

  // Capture payload of an accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_hit  <= match;
      hold_diff <= diff;
    end
  end

endmodule

>>> design/coa_queue.sv
// Short queue decoupling the front end from the back end.
module coa_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  coa_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output coa_pkg::cmd_t dout,
  output logic          empty
);

  localparam int DEPTH = coa_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  coa_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign dout  = entries[rd_ptr];

  // Store incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

>>> design/coa_divider.sv
// Bit-serial signed divider: window sum over sample count, truncated toward zero.
module coa_divider #(
  parameter int SUM_W = 55,
  parameter int CNT_W = 7
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [SUM_W-1:0]         dividend,
  input  logic [CNT_W-1:0]                divisor,
  output logic                            done,
  output logic [coa_pkg::SAMPLE_W-1:0]    quotient
);

  localparam int SW     = coa_pkg::SAMPLE_W;
  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy;
  logic              fin;
  logic              neg;
  logic [CNT_W-1:0]  rem;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  dvs;
  logic [STEP_W-1:0] step;

  logic [CNT_W:0] shifted;
  logic [CNT_W:0] trial;
  logic           ge;

  // One restoring step: shift in a dividend bit, subtract if it fits
  assign shifted = {rem, quo[SUM_W-1]};
  assign trial   = shifted - {1'b0, dvs};
  assign ge      = (shifted >= {1'b0, dvs});

  // Sequence control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (step == STEP_W'(SUM_W - 1))) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end
  end

  // Datapath: load magnitude, iterate, apply sign
  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[SUM_W-1];
      quo  <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem  <= '0;
      dvs  <= divisor;
      step <= '0;
    end else if (busy) begin
      rem  <= ge ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo  <= {quo[SUM_W-2:0], ge};
      step <= step + 1'b1;
    end
    if (fin) begin
      quotient <= neg ? (~quo[SW-1:0] + 1'b1) : quo[SW-1:0];
    end
  end

endmodule

>>> design/coa_back.sv
// Back end: sample window, running sum, average and result register.
module coa_back #(
  parameter int WINDOW = coa_pkg::WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_empty,
  input  coa_pkg::cmd_t                       q_head,
  output logic                                q_pop,
  output logic                                empty,
  input  logic                                pop,
  output logic                                accepted,
  output logic signed [coa_pkg::SAMPLE_W-1:0] offset_estimate,
  output logic [coa_pkg::HELD_W-1:0]          samples_held
);

  localparam int SW    = coa_pkg::SAMPLE_W;
  localparam int HW    = coa_pkg::HELD_W;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = SW + CNT_W;

  coa_pkg::back_state_t state, state_next;

  logic signed [SW-1:0]    window_mem [WINDOW];
  logic signed [SW-1:0]    rd_data;
  logic signed [SW-1:0]    sample;
  logic [IDX_W-1:0]        write_index;
  logic [CNT_W-1:0]        sample_count;
  logic signed [SUM_W-1:0] window_sum;
  logic signed [SW-1:0]    estimate_reg;
  logic                    out_valid;

  logic                 out_free;
  logic                 mem_rd;
  logic                 div_start;
  logic                 div_done;
  logic [SW-1:0]        div_quot;
  logic                 window_full;
  logic [CNT_W+HW-1:0]  cnt_ext;
  logic [SUM_W-1:0]     add_in;
  logic [SUM_W-1:0]     sub_in;

  assign empty       = !out_valid;
  assign out_free    = !out_valid || pop;
  assign window_full = (sample_count >= CNT_W'(WINDOW));
  assign cnt_ext     = {{HW{1'b0}}, sample_count};
  assign add_in      = {{CNT_W{sample[SW-1]}}, sample};
  assign sub_in      = window_full ? {{CNT_W{rd_data[SW-1]}}, rd_data} : '0;

  // Next state and handshake to queue and divider
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mem_rd     = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      coa_pkg::BK_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          if (q_head.hit) begin
            mem_rd     = 1'b1;
            state_next = coa_pkg::BK_READ;
          end
        end
      end
      coa_pkg::BK_READ: begin
        state_next = coa_pkg::BK_START;
      end
      coa_pkg::BK_START: begin
        div_start  = 1'b1;
        state_next = coa_pkg::BK_WAIT;
      end
      coa_pkg::BK_WAIT: begin
        if (div_done) begin
          state_next = coa_pkg::BK_IDLE;
        end
      end
      default: state_next = coa_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= coa_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Window memory: read the oldest slot, then overwrite it
  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_data <= window_mem[write_index];
    end
    if (state == coa_pkg::BK_READ) begin
      window_mem[write_index] <= sample;
    end
  end

  // Hold the new sample while the update runs
  always_ff @(posedge clk) begin
    if (mem_rd) begin
      sample <= q_head.sample;
    end
  end

  // Update running sum, count and write slot; latch the estimate
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index  <= '0;
      sample_count <= '0;
      window_sum   <= '0;
      estimate_reg <= '0;
    end else begin
      if (state == coa_pkg::BK_READ) begin
        window_sum <= window_sum + add_in - sub_in;
        if (!window_full) begin
          sample_count <= sample_count + 1'b1;
        end
        write_index <= (write_index == IDX_W'(WINDOW - 1)) ? '0 : write_index + 1'b1;
      end
      if (div_done) begin
        estimate_reg <= div_quot;
      end
    end
  end

  // Result register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((q_pop && !q_head.hit) || div_done) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (q_pop && !q_head.hit) begin
      accepted        <= 1'b0;
      offset_estimate <= estimate_reg;
      samples_held    <= cnt_ext[HW-1:0];
    end else if (div_done) begin
      accepted        <= 1'b1;
      offset_estimate <= div_quot;
      samples_held    <= cnt_ext[HW-1:0];
    end
  end

  coa_divider #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (window_sum),
    .divisor  (sample_count),
    .done     (div_done),
    .quotient (div_quot)
  );

endmodule

>>> design/clock_offset_window_average.sv
// Top level of the clock offset window average block.
//
//  channel   handshake        payload
//  input     push / full      func, tag, is_reply, client_request_time,
//                             server_time, receive_time
//  result    empty / pop      accepted, offset_estimate, samples_held
//
// Every request gives one result. Requests, queries and unmatched replies
// pass through the staging register and the queue into the result register;
// a matched reply also goes through the window update and the divider.
// Synchronous reset clears pending tag, count, sum and estimate; window
// slots are not cleared and their contents are used only once written.
// full rises when the staging register and the two-entry queue are taken.
`include "clock_offset_window_average_assert.svh"

module clock_offset_window_average #(
  parameter int WINDOW = coa_pkg::WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic                                func,
  input  logic [coa_pkg::TAG_W-1:0]           tag,
  input  logic                                is_reply,
  input  logic [coa_pkg::TIME_W-1:0]          client_request_time,
  input  logic [coa_pkg::TIME_W-1:0]          server_time,
  input  logic [coa_pkg::TIME_W-1:0]          receive_time,
  output logic                                empty,
  input  logic                                pop,
  output logic                                accepted,
  output logic signed [coa_pkg::SAMPLE_W-1:0] offset_estimate,
  output logic [coa_pkg::HELD_W-1:0]          samples_held
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  coa_pkg::cmd_t q_in;
  coa_pkg::cmd_t q_head;

  coa_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .push                (push),
    .full                (full),
    .func                (func),
    .tag                 (tag),
    .is_reply            (is_reply),
    .client_request_time (client_request_time),
    .server_time         (server_time),
    .receive_time        (receive_time),
    .q_push              (q_push),
    .q_data              (q_in),
    .q_full              (q_full)
  );

  coa_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  coa_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .empty           (empty),
    .pop             (pop),
    .accepted        (accepted),
    .offset_estimate (offset_estimate),
    .samples_held    (samples_held)
  );

  // Check the queue handshake between front and back, and that an unpopped result is held
  `COA_ASSERT_IMPL(a_no_push_full, clk, rst, q_full, !q_push, "front pushed into a full queue")
  `COA_ASSERT_IMPL(a_no_pop_empty, clk, rst, q_empty, !q_pop, "back popped an empty queue")
  `COA_ASSERT_NEXT(a_result_held, clk, rst, (!empty && !pop), !empty, "result dropped unpopped")

endmodule

>>> test/clock_offset_window_average_checker.sv
// Result checker for the clock offset window average block.
module clock_offset_window_average_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  input  logic                                full,
  input  logic                                func,
  input  logic [coa_pkg::TAG_W-1:0]           tag,
  input  logic                                is_reply,
  input  logic [coa_pkg::TIME_W-1:0]          client_request_time,
  input  logic [coa_pkg::TIME_W-1:0]          server_time,
  input  logic [coa_pkg::TIME_W-1:0]          receive_time,
  input  logic                                empty,
  input  logic                                pop,
  input  logic                                accepted,
  input  logic signed [coa_pkg::SAMPLE_W-1:0] offset_estimate,
  input  logic [coa_pkg::HELD_W-1:0]          samples_held,
  output int                                  mismatches,
  output int                                  results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import coa_pkg::*;

  localparam longint OFFSET_MAX = 64'sd140737488355327;
  localparam longint OFFSET_MIN = -64'sd140737488355328;
  localparam int     SHOWN_MAX  = 10;

  typedef struct packed {
    logic                       accepted;
    logic signed [SAMPLE_W-1:0] estimate;
    logic [HELD_W-1:0]          held;
  } offset_report_t;

  // Predicted state of the estimator
  logic [TAG_W-1:0]           open_tag;
  logic                       open_valid;
  logic signed [SAMPLE_W-1:0] offset_ring [WINDOW_DEF];
  int                         ring_next;
  int                         ring_fill;
  longint                     ring_sum;
  logic signed [SAMPLE_W-1:0] average;

  offset_report_t reports_due [$];
  int             fault_count;

  // Half the sum of both one-way differences, clamped to the sample width
  function automatic logic signed [SAMPLE_W-1:0] exchange_offset(
      logic [TIME_W-1:0] req, logic [TIME_W-1:0] srv, logic [TIME_W-1:0] rcv);
    longint d;
    d = (longint'({2'b00, srv}) - longint'({2'b00, req}))
      + (longint'({2'b00, srv}) - longint'({2'b00, rcv}));
    d = d / 2;
    if (d > OFFSET_MAX) d = OFFSET_MAX;
    else if (d < OFFSET_MIN) d = OFFSET_MIN;
    return d[SAMPLE_W-1:0];
  endfunction

  // Advance the predicted state by one request and return its result
  function automatic offset_report_t fold_event(
      logic f, logic [TAG_W-1:0] t, logic r,
      logic [TIME_W-1:0] req, logic [TIME_W-1:0] srv, logic [TIME_W-1:0] rcv);
    offset_report_t             rep;
    logic signed [SAMPLE_W-1:0] s;
    longint                     q;
    rep.accepted = 1'b0;
    if (f == EV_REQUEST) begin
      open_tag   = t;
      open_valid = 1'b1;
    end else if (r == MSG_REPLY && open_valid && t == open_tag) begin
      s = exchange_offset(req, srv, rcv);
      // drop the oldest sample once the window is full
      if (ring_fill >= WINDOW_DEF) ring_sum -= offset_ring[ring_next];
      else ring_fill++;
      offset_ring[ring_next] = s;
      ring_sum += s;
      ring_next = (ring_next + 1 >= WINDOW_DEF) ? 0 : ring_next + 1;
      q = ring_sum / ring_fill;
      average = q[SAMPLE_W-1:0];
      open_valid = 1'b0;
      rep.accepted = 1'b1;
    end
    rep.estimate = average;
    rep.held     = ring_fill[HELD_W-1:0];
    return rep;
  endfunction

  // Record each accepted request and check each accepted result
  always @(posedge clk) begin
    offset_report_t got;
    offset_report_t want;
    offset_report_t fresh;
    if (rst) begin
      open_tag    = '0;
      open_valid  = 1'b0;
      ring_next   = 0;
      ring_fill   = 0;
      ring_sum    = 0;
      average     = '0;
      fault_count = 0;
      reports_due.delete();
      mismatches  <= 0;
      results_due <= 0;
    end else begin
      if (push && !full) begin
        fresh = fold_event(func, tag, is_reply, client_request_time,
                           server_time, receive_time);
        reports_due = {reports_due, fresh};
      end
      if (pop && !empty) begin
        got = {accepted, offset_estimate, samples_held};
        if (reports_due.size() == 0) begin
          fault_count++;
          if (fault_count <= SHOWN_MAX)
            $display("%0t: result with none outstanding: accepted=%0b estimate=%0d held=%0d",
                     $realtime, got.accepted, $signed(got.estimate), got.held);
        end else begin
          want = reports_due.pop_front();
          if (got.accepted !== want.accepted || got.estimate !== want.estimate ||
              got.held !== want.held) begin
            fault_count++;
            if (fault_count <= SHOWN_MAX)
              $display("%0t: mismatch: expected accepted=%0b estimate=%0d held=%0d, %s%0b %s%0d %s%0d",
                       $realtime, want.accepted, $signed(want.estimate), want.held,
                       "got accepted=", got.accepted, "estimate=", $signed(got.estimate),
                       "held=", got.held);
          end
        end
      end
      mismatches  <= fault_count;
      results_due <= reports_due.size();
    end
  end

endmodule

>>> test/tb.sv
// Top of the clock offset window average testbench: stimulus, flow control and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import coa_pkg::*;

  localparam int RANDOM_ITEMS   = 850;
  localparam int HOLD_AFTER     = 150;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 100;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [TAG_W-1:0]  TAG_ALL  = '1;

  typedef enum int {
    FREE_RUN,
    SEND_SPARSE,
    RECV_STALL,
    BOTH_IDLE
  } idle_mode_t;

  typedef struct packed {
    logic              func;
    logic [TAG_W-1:0]  tag;
    logic              is_reply;
    logic [TIME_W-1:0] req;
    logic [TIME_W-1:0] srv;
    logic [TIME_W-1:0] rcv;
  } ntp_event_t;

  logic                       clk                 = 1'b0;
  logic                       rst                 = 1'b1;
  logic                       push                = 1'b0;
  logic                       full;
  logic                       func                = 1'b0;
  logic [TAG_W-1:0]           tag                 = '0;
  logic                       is_reply            = 1'b0;
  logic [TIME_W-1:0]          client_request_time = '0;
  logic [TIME_W-1:0]          server_time         = '0;
  logic [TIME_W-1:0]          receive_time        = '0;
  logic                       empty;
  logic                       pop                 = 1'b0;
  logic                       accepted;
  logic signed [SAMPLE_W-1:0] offset_estimate;
  logic [HELD_W-1:0]          samples_held;

  int               mismatches;
  int               results_due;
  int               items_sent   = 0;
  int               quiet_cycles = 0;
  idle_mode_t       idle_mode    = FREE_RUN;
  logic [TAG_W-1:0] last_tag     = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  clock_offset_window_average dut (
    .clk                 (clk),
    .rst                 (rst),
    .push                (push),
    .full                (full),
    .func                (func),
    .tag                 (tag),
    .is_reply            (is_reply),
    .client_request_time (client_request_time),
    .server_time         (server_time),
    .receive_time        (receive_time),
    .empty               (empty),
    .pop                 (pop),
    .accepted            (accepted),
    .offset_estimate     (offset_estimate),
    .samples_held        (samples_held)
  );

  clock_offset_window_average_checker offset_check (
    .clk                 (clk),
    .rst                 (rst),
    .push                (push),
    .full                (full),
    .func                (func),
    .tag                 (tag),
    .is_reply            (is_reply),
    .client_request_time (client_request_time),
    .server_time         (server_time),
    .receive_time        (receive_time),
    .empty               (empty),
    .pop                 (pop),
    .accepted            (accepted),
    .offset_estimate     (offset_estimate),
    .samples_held        (samples_held),
    .mismatches          (mismatches),
    .results_due         (results_due)
  );

  // Abort when neither side moves for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Idle chance per cycle for the sender or the receiver in the current mode
  function automatic int idle_pct(bit receiver);
    case (idle_mode)
      SEND_SPARSE: return receiver ? 0 : 79;
      RECV_STALL:  return receiver ? 79 : 0;
      BOTH_IDLE:   return 35;
      default:     return 0;
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] any_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_W-1:0];
  endfunction

  // Hold push low for a random gap, then present the request until taken
  task automatic offer(input ntp_event_t ev);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct(1'b0)) gap++;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push                <= 1'b1;
    func                <= ev.func;
    tag                 <= ev.tag;
    is_reply            <= ev.is_reply;
    client_request_time <= ev.req;
    server_time         <= ev.srv;
    receive_time        <= ev.rcv;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  // Plausible round trip around a random offset; sometimes raw times
  task automatic exchange_times(output logic [TIME_W-1:0] req, output logic [TIME_W-1:0] srv,
                                output logic [TIME_W-1:0] rcv);
    logic [63:0] w;
    longint      span;
    longint      skew;
    longint      rtt;
    if ($urandom_range(7) == 0) begin
      req = any_time();
      srv = any_time();
      rcv = any_time();
    end else begin
      w    = {$urandom, $urandom};
      req  = {2'b01, w[59:0]};
      span = longint'(1) << $urandom_range(2, 46);
      skew = $signed({$urandom, $urandom}) % span;
      w    = {$urandom, $urandom};
      rtt  = longint'({1'b0, w[62:0]}) % span;
      rcv  = TIME_W'(req + rtt);
      srv  = TIME_W'(req + (rtt / 2 + skew));
    end
  endtask

  // Request, an optional query and an optional stray reply, then the matching reply
  task automatic run_exchange();
    logic [TAG_W-1:0]  t;
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic [TIME_W-1:0] c;
    t = $urandom;
    offer('{EV_REQUEST, t, 1'($urandom), any_time(), any_time(), any_time()});
    if ($urandom_range(4) == 0)
      offer('{EV_RECEIVED, ($urandom_range(1) ? t : TAG_W'($urandom)), MSG_QUERY,
              any_time(), any_time(), any_time()});
    if ($urandom_range(9) == 0)
      offer('{EV_RECEIVED, t ^ (32'd1 << $urandom_range(31)), MSG_REPLY,
              any_time(), any_time(), any_time()});
    exchange_times(a, b, c);
    offer('{EV_RECEIVED, t, MSG_REPLY, a, b, c});
    last_tag = t;
  endtask

  // Unstructured request, often reusing the last tag
  function automatic ntp_event_t noise_event();
    ntp_event_t ev;
    ev.func     = 1'($urandom);
    ev.tag      = $urandom_range(1) ? last_tag : TAG_W'($urandom);
    ev.is_reply = 1'($urandom);
    ev.req      = any_time();
    ev.srv      = any_time();
    ev.rcv      = any_time();
    return ev;
  endfunction

  // Pop at random, with one long hold-off to back up the input
  initial begin
    bit held_off;
    held_off = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (!held_off && items_sent >= HOLD_AFTER) begin
        held_off = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pop <= ($urandom_range(99) >= idle_pct(1'b1));
      end
    end
  end

  initial begin
    int random_start;
    int n;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reply with nothing pending
    offer('{EV_RECEIVED, 32'h0, MSG_REPLY, 62'd0, 62'd5, 62'd1});
    // tag zero; matched reply clamps to the largest offset
    offer('{EV_REQUEST, 32'h0, MSG_REPLY, TIME_MAX, TIME_MAX, TIME_MAX});
    offer('{EV_RECEIVED, 32'h0, MSG_REPLY, 62'd0, TIME_MAX, 62'd0});
    // same reply again after the request was consumed
    offer('{EV_RECEIVED, 32'h0, MSG_REPLY, 62'd0, TIME_MAX, 62'd0});
    // query keeps the request pending, wrong tag is dropped, then clamp low
    offer('{EV_REQUEST, TAG_ALL, MSG_QUERY, 62'd0, 62'd0, 62'd0});
    offer('{EV_RECEIVED, TAG_ALL, MSG_QUERY, 62'd0, TIME_MAX, 62'd0});
    offer('{EV_RECEIVED, TAG_ALL - 1, MSG_REPLY, 62'd0, TIME_MAX, 62'd0});
    offer('{EV_RECEIVED, TAG_ALL, MSG_REPLY, TIME_MAX, 62'd0, TIME_MAX});
    // newer request replaces the older one; odd negative sum truncates up
    offer('{EV_REQUEST, 32'h1234_5678, MSG_QUERY, 62'd0, 62'd0, 62'd0});
    offer('{EV_REQUEST, 32'h8765_4321, MSG_QUERY, 62'd0, 62'd0, 62'd0});
    offer('{EV_RECEIVED, 32'h1234_5678, MSG_REPLY, 62'd10, 62'd5, 62'd7});
    offer('{EV_RECEIVED, 32'h8765_4321, MSG_REPLY, 62'd10, 62'd5, 62'd7});
    // odd positive sum truncates down
    offer('{EV_REQUEST, 32'hA5A5_A5A5, MSG_QUERY, 62'd0, 62'd0, 62'd0});
    offer('{EV_RECEIVED, 32'hA5A5_A5A5, MSG_REPLY, 62'd1, 62'd5, 62'd0});
    // zero and all-ones times give a zero offset
    offer('{EV_REQUEST, 32'h5A5A_5A5A, MSG_REPLY, 62'd0, 62'd0, 62'd0});
    offer('{EV_RECEIVED, 32'h5A5A_5A5A, MSG_REPLY, 62'd0, 62'd0, 62'd0});
    offer('{EV_REQUEST, 32'h0000_0007, MSG_QUERY, 62'd0, 62'd0, 62'd0});
    offer('{EV_RECEIVED, 32'h0000_0007, MSG_REPLY, TIME_MAX, TIME_MAX, TIME_MAX});

    // random traffic, stepping through the idle modes
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      n = items_sent - random_start;
      if (n < 250)      idle_mode = FREE_RUN;
      else if (n < 450) idle_mode = SEND_SPARSE;
      else if (n < 650) idle_mode = RECV_STALL;
      else if (n < 800) idle_mode = BOTH_IDLE;
      else              idle_mode = FREE_RUN;
      if ($urandom_range(3) != 0) run_exchange();
      else offer(noise_event());
    end
    push <= 1'b0;

    // drain, then allow for late or stray results
    do @(posedge clk); while (results_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && results_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
